>>> rtl/rfo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ring FIFO with overwrite.
// No dependencies; imported by every module of the block.
package rfo_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FIELD_W            = 32;
   localparam int CAP_W              = 5;
   localparam int CAP_RESET          = 16;

   typedef enum logic [1:0] {
      ACT_WRITE     = 2'd0,
      ACT_READ      = 2'd1,
      ACT_OVERWRITE = 2'd2,
      ACT_CLEAR     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [FIELD_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] data_out;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      status_type status;
      logic       take_head;
   } op_result_type;

endpackage

>>> rtl/rfo_cell.sv
`timescale 1ns / 1ps
// One storage cell of the shifting FIFO chain.
// Depends on rfo_pkg for the cell control struct.
module rfo_cell #(
   parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  rfo_pkg::cell_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   output logic [DATA_WIDTH-1:0] data
);
   import rfo_pkg::*;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      priority if (ctrl.load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = next_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> rtl/rfo_ctrl.sv
`timescale 1ns / 1ps
// Fill count, capacity register and per-cell shift/load decode.
// Depends on rfo_pkg; drives the rfo_cell chain.
module rfo_ctrl #(
   parameter int DEPTH = rfo_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  rfo_pkg::action_type           action,
   input  logic                          csr_we,
   input  logic [rfo_pkg::CAP_W-1:0]     csr_wdata,
   output rfo_pkg::cell_ctrl_type        cell_ctrl [DEPTH],
   output rfo_pkg::op_result_type        result
);
   import rfo_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CAP_RST_INT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
   localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CAP_RST_INT);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] fill_dec;
   logic [IDX_W-1:0] pos;
   logic             full, empty, shift, load;
   logic [DEPTH-1:0] load_vec;

   assign full     = fill_ff >= cap_ff;
   assign empty    = fill_ff == '0;
   assign fill_dec = fill_ff - CNT_W'(1);

   always_comb begin
      if (32'(csr_wdata) == 32'd0) begin
         cap_in = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(DEPTH)) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = CNT_W'(csr_wdata);
      end
   end

   always_comb begin
      fill_in          = fill_ff;
      shift            = 1'b0;
      load             = 1'b0;
      pos              = fill_ff[IDX_W-1:0];
      result.status    = ST_OK;
      result.take_head = 1'b0;
      unique case (action)
         ACT_WRITE: begin
            if (full) begin
               result.status = ST_FULL;
            end else begin
               load    = 1'b1;
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         ACT_READ: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.take_head = 1'b1;
               shift            = 1'b1;
               fill_in          = fill_dec;
            end
         end
         ACT_OVERWRITE: begin
            load = 1'b1;
            if (full) begin
               shift = 1'b1;
               pos   = fill_dec[IDX_W-1:0];
            end else begin
               fill_in = fill_ff + CNT_W'(1);
            end
         end
         ACT_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_dec
      assign load_vec[i]        = fire && load && (pos == IDX_W'(i));
      assign cell_ctrl[i].load  = load_vec[i];
      assign cell_ctrl[i].shift = fire && shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cap_ff  <= CAP_RST;
      end else if (csr_we) begin
         fill_ff <= '0;
         cap_ff  <= cap_in;
      end else if (fire) begin
         fill_ff <= fill_in;
      end
   end

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_ff)
      else $error("fill count above capacity");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0(load_vec))
      else $error("more than one cell loaded");

   a_csr_empties: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> (fill_ff == '0) && (cap_ff != '0) && (cap_ff <= CNT_W'(DEPTH)))
      else $error("capacity write left buffer non-empty or capacity out of range");

endmodule

>>> rtl/ring_fifo_with_overwrite.sv
`timescale 1ns / 1ps
// Ring FIFO with overwrite, built as a shifting chain of storage cells.
// Responses are registered; the output register refills as it drains.
// Throughput: one transfer per cycle, paused while a response is stalled.
// Reset: synchronous; empties the buffer and sets capacity to min(16, DEPTH).
// Depends on rfo_pkg, rfo_cell and rfo_ctrl.
module ring_fifo_with_overwrite #(
   parameter int DEPTH      = rfo_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = rfo_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rfo_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rfo_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [rfo_pkg::CAP_W-1:0] csr_wdata
);
   import rfo_pkg::*;

   logic                  fire;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   cell_ctrl_type         cell_ctrl [DEPTH];
   op_result_type         result;
   logic [DATA_WIDTH-1:0] wdata;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;
   assign wdata     = DATA_WIDTH'(req_data.data_in);

   rfo_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .action    (req_data.action),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cell_ctrl (cell_ctrl),
      .result    (result)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         rfo_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[i]),
            .load_data (wdata),
            .next_data (wdata),
            .data      (cell_data[i])
         );
      end else begin : g_mid
         rfo_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl[i]),
            .load_data (wdata),
            .next_data (cell_data[i+1]),
            .data      (cell_data[i])
         );
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = result.status;
         rsp_data_in.data_out = result.take_head ? FIELD_W'(cell_data[0]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |-> rsp_data_ff.data_out == '0)
      else $error("failed action returned nonzero data");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for ring_fifo_with_overwrite: directed and random actions across capacity settings,
// checked against a scoreboard that models the ring buffer. Depends on rfo_pkg and the block RTL.
module tb;
   import rfo_pkg::*;

   localparam int SLOTS      = DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_LEN  = 105;
   localparam int HOLD_LEN   = 80;

   class ring_scoreboard;
      logic [FIELD_W-1:0] slots [SLOTS];
      int unsigned head, tail, fill, cap;
      rsp_type due [$];
      int mismatches, requests, responses, full_hits, empty_hits, dropped, cap_writes;

      function new();
         cap = SLOTS;
         reset_pointers();
      endfunction

      function void reset_pointers();
         head = 0;
         tail = 0;
         fill = 0;
      endfunction

      function int unsigned step_slot(int unsigned s);
         return (s + 1 >= cap) ? 0 : s + 1;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         if (value == 0) cap = 1;
         else if (value > SLOTS) cap = SLOTS;
         else cap = 32'(value);
         reset_pointers();
         cap_writes++;
      endfunction

      function void push(logic [FIELD_W-1:0] value);
         slots[tail] = value;
         tail = step_slot(tail);
         fill++;
      endfunction

      function void note_request(req_type item);
         rsp_type exp;
         exp.data_out = '0;
         exp.status = ST_OK;
         case (item.action)
            ACT_WRITE: begin
               if (fill >= cap) begin
                  exp.status = ST_FULL;
                  full_hits++;
               end else push(item.data_in);
            end
            ACT_READ: begin
               if (fill == 0) begin
                  exp.status = ST_EMPTY;
                  empty_hits++;
               end else begin
                  exp.data_out = slots[head];
                  head = step_slot(head);
                  fill--;
                  if (fill == 0) reset_pointers();
               end
            end
            ACT_OVERWRITE: begin
               if (fill >= cap) begin
                  head = step_slot(head);
                  fill--;
                  dropped++;
               end
               push(item.data_in);
            end
            default: reset_pointers();
         endcase
         due.push_back(exp);
         requests++;
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         responses++;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with nothing pending: data %h status %0d",
                        responses, got.data_out, got.status);
            return;
         end
         exp = due.pop_front();
         if (got.data_out !== exp.data_out || got.status !== exp.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d: expected data %h status %0d, got data %h status %0d",
                        responses, exp.data_out, exp.status, got.data_out, got.status);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [CAP_W-1:0]    csr_wdata = '0;

   ring_scoreboard sb;
   bit   idle_on = 1'b1;
   bit   hold_trigger = 1'b0;
   bit   filling_up = 1'b1;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   int   cap_list [12] = '{16, 1, 3, 7, 31, 0, 2, 12, 17, 4, 8, 16};

   ring_fifo_with_overwrite dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_left == 0 && hold_trigger) begin
         hold_left = HOLD_LEN;
         hold_trigger = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else rsp_stall <= idle_on && ($urandom_range(99) < 29);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("no transfer for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   task automatic send_request(input req_type item);
      while (idle_on && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_capacity(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type item;
      int roll;
      if ($urandom_range(sb.cap + 1) == 0) filling_up = !filling_up;
      roll = $urandom_range(99);
      if (filling_up) begin
         if (roll < 70) item.action = ACT_WRITE;
         else if (roll < 90) item.action = ACT_OVERWRITE;
         else if (roll < 98) item.action = ACT_READ;
         else item.action = ACT_CLEAR;
      end else begin
         if (roll < 80) item.action = ACT_READ;
         else if (roll < 90) item.action = ACT_WRITE;
         else if (roll < 98) item.action = ACT_OVERWRITE;
         else item.action = ACT_CLEAR;
      end
      case ($urandom_range(9))
         0: item.data_in = '0;
         1: item.data_in = '1;
         default: item.data_in = $urandom;
      endcase
      return item;
   endfunction

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request('{ACT_READ, 32'h0});
      send_request('{ACT_WRITE, 32'h0000_0000});
      send_request('{ACT_WRITE, 32'hFFFF_FFFF});
      send_request('{ACT_OVERWRITE, 32'h1234_5678});
      send_request('{ACT_READ, 32'h0});
      send_request('{ACT_CLEAR, 32'hFFFF_FFFF});
      send_request('{ACT_READ, 32'h0});
      write_capacity(5'd0);
      send_request('{ACT_WRITE, 32'hAAAA_AAAA});
      send_request('{ACT_WRITE, 32'h5555_5555});
      send_request('{ACT_OVERWRITE, 32'h5555_5555});
      send_request('{ACT_READ, 32'h0});
      send_request('{ACT_READ, 32'h0});
      write_capacity(5'd2);
      send_request('{ACT_WRITE, 32'h1});
      send_request('{ACT_WRITE, 32'h2});
      send_request('{ACT_WRITE, 32'h3});
      send_request('{ACT_OVERWRITE, 32'h4});
      send_request('{ACT_READ, 32'h0});
      send_request('{ACT_READ, 32'h0});
      send_request('{ACT_READ, 32'h0});
      write_capacity(5'd17);
      send_request('{ACT_OVERWRITE, 32'h8000_0000});
      send_request('{ACT_READ, 32'h0});

      foreach (cap_list[p]) begin
         write_capacity(CAP_W'(cap_list[p]));
         idle_on = (p != 4);
         if (p == 6) hold_trigger = 1'b1;
         filling_up = 1'b1;
         repeat (PHASE_LEN) send_request(random_request());
      end
      idle_on = 1'b1;

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      $display("%0d transfers in, %0d out, %0d capacity writes", sb.requests, sb.responses,
               sb.cap_writes);
      $display("full on write %0d, empty on read %0d, oldest dropped %0d, mismatches %0d",
               sb.full_hits, sb.empty_hits, sb.dropped, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
